// ===== hdl/bsc_pkg.sv =====
// bsc_pkg: sizes, command and register codes, sequencer state and control structs
// for the banker's safety check block; no dependencies
package bsc_pkg;

   localparam int MAX_PROCESSES = 8;
   localparam int MAX_RESOURCES = 4;
   localparam int UNIT_WIDTH    = 8;
   localparam int FREE_WIDTH    = UNIT_WIDTH + 4;

   localparam int PROC_W  = $clog2(MAX_PROCESSES);
   localparam int RES_W   = $clog2(MAX_RESOURCES);
   localparam int PCNT_W  = $clog2(MAX_PROCESSES + 1);
   localparam int RCNT_W  = $clog2(MAX_RESOURCES + 1);
   localparam int MEM_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
   localparam int MEM_WIDTH = 2 * UNIT_WIDTH;

   localparam int CMD_W      = 2;
   localparam int CFG_PROC_W = 4;
   localparam int CFG_RES_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESSES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESOURCES = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_TEST,
      ST_RFETCH,
      ST_RADD,
      ST_NEXT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic skip;
      logic fits;
      logic res_last;
      logic proc_last;
      logic pass_last;
      logic emit_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic clear_run;
      logic res_clear;
      logic res_step;
      logic free_write;
      logic mark_done;
      logic proc_step;
      logic emit_beat;
   } ctrl_type;

endpackage

// ===== hdl/bsc_if.sv =====
// bsc_if: request, response and register-write channels of the safety check
// depends on bsc_pkg
interface bsc_req_if;
   import bsc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [PROC_W-1:0]     process;
   logic [RES_W-1:0]      resource;
   logic [UNIT_WIDTH-1:0] allocated;
   logic [UNIT_WIDTH-1:0] maximum;
   logic [UNIT_WIDTH-1:0] available;
   modport source (output valid, cmd, process, resource, allocated, maximum, available,
                   input ready);
   modport sink   (input valid, cmd, process, resource, allocated, maximum, available,
                   output ready);
endinterface

interface bsc_rsp_if;
   import bsc_pkg::*;
   logic              valid;
   logic              ready;
   logic              safe;
   logic [PROC_W-1:0] granted_process;
   logic [PROC_W-1:0] position;
   logic              last;
   modport source (output valid, safe, granted_process, position, last, input ready);
   modport sink   (input valid, safe, granted_process, position, last, output ready);
endinterface

interface bsc_csr_if;
   import bsc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bankers_safety_check.sv =====
// bankers_safety_check: banker's algorithm safety test over loaded matrices
// depends on bsc_pkg, bsc_if, bsc_ram, bsc_alu, bsc_ctrl
//
//   channel   direction  beat contents
//   req_bus   in         cmd, process, resource, allocated, maximum, available
//   rsp_bus   out        safe, granted_process, position, last
//   csr_bus   in         index, data (processes_in_use, resources_in_use)
//
// load beats are accepted whenever the sequencer is idle; a check beat keeps req_bus not ready until its
// last response beat is registered
// each process visit steps through scan and advance, plus a fetch and test per resource compared
// while unfinished and a fetch and add per resource released once it fits, bounded by the single
// matrix read port and the shared adder; a check runs np passes of np visits, then emits one
// response beat per cycle while rsp_bus is not stalled
// reset returns the sequencer to idle, clears the free amounts and sets the registers to 5
// processes and 3 resources; matrix entries hold nothing until loaded
// a stalled rsp_bus holds the current response beat
module bankers_safety_check (
   input logic  clock,
   input logic  reset,
   bsc_req_if.sink   req_bus,
   bsc_rsp_if.source rsp_bus,
   bsc_csr_if.sink   csr_bus
);
   import bsc_pkg::*;

   logic [CFG_PROC_W-1:0] cfg_proc_ff;
   logic [CFG_RES_W-1:0]  cfg_res_ff;
   logic [PCNT_W-1:0]     np_eff;
   logic [RCNT_W-1:0]     nr_eff;

   state_type  state;
   ctrl_type   ctrl;
   status_type status;

   logic [PROC_W-1:0]     proc_ff;
   logic [PROC_W-1:0]     pass_ff;
   logic [RES_W-1:0]      res_ff;
   logic [PROC_W-1:0]     emit_ff;
   logic [PCNT_W-1:0]     count_ff;
   logic [MAX_PROCESSES-1:0] flags_ff;
   logic [PROC_W-1:0]     order_ff [MAX_PROCESSES];
   logic [FREE_WIDTH-1:0] free_ff [MAX_RESOURCES];

   logic                  req_fire;
   logic                  all_done;
   logic                  mem_wr_en;
   logic [MEM_WIDTH-1:0]  mem_rd_data;
   logic                  fits;
   logic [FREE_WIDTH-1:0] released;

   logic                  rsp_valid_ff;
   logic                  rsp_safe_ff;
   logic [PROC_W-1:0]     rsp_granted_ff;
   logic [PROC_W-1:0]     rsp_position_ff;
   logic                  rsp_last_ff;

   // registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_proc_ff <= CFG_PROC_W'(5);
         cfg_res_ff  <= CFG_RES_W'(3);
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_PROCESSES) cfg_proc_ff <= CFG_PROC_W'(csr_bus.data);
         if (csr_bus.index == CSR_RESOURCES) cfg_res_ff  <= CFG_RES_W'(csr_bus.data);
      end
   end

   assign np_eff = (cfg_proc_ff == '0) ? PCNT_W'(1) :
                   (PCNT_W'(cfg_proc_ff) > PCNT_W'(MAX_PROCESSES)) ? PCNT_W'(MAX_PROCESSES) :
                   PCNT_W'(cfg_proc_ff);
   assign nr_eff = (cfg_res_ff == '0) ? RCNT_W'(1) :
                   (RCNT_W'(cfg_res_ff) > RCNT_W'(MAX_RESOURCES)) ? RCNT_W'(MAX_RESOURCES) :
                   RCNT_W'(cfg_res_ff);

   // matrix memory, claim in the upper half
   assign req_bus.ready = (state == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign mem_wr_en     = req_fire && (req_bus.cmd == CMD_LOAD_ENTRY);

   bsc_ram #(
      .WIDTH (MEM_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr ({req_bus.process, req_bus.resource}),
      .wr_data ({req_bus.maximum, req_bus.allocated}),
      .rd_addr ({proc_ff, res_ff}),
      .rd_data (mem_rd_data)
   );

   bsc_alu u_alu (
      .free_units  (free_ff[res_ff]),
      .held_units  (mem_rd_data[UNIT_WIDTH-1:0]),
      .claim_units (mem_rd_data[MEM_WIDTH-1:UNIT_WIDTH]),
      .fits        (fits),
      .released    (released)
   );

   // sequencer
   assign all_done = (count_ff == np_eff);

   always_comb begin
      status.start     = req_fire && (req_bus.cmd == CMD_CHECK);
      status.skip      = flags_ff[proc_ff];
      status.fits      = fits;
      status.res_last  = (RCNT_W'(res_ff) == nr_eff - RCNT_W'(1));
      status.proc_last = (PCNT_W'(proc_ff) == np_eff - PCNT_W'(1));
      status.pass_last = (PCNT_W'(pass_ff) == np_eff - PCNT_W'(1));
      status.emit_last = !all_done || (PCNT_W'(emit_ff) == np_eff - PCNT_W'(1));
      status.out_free  = !rsp_valid_ff || rsp_bus.ready;
   end

   bsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .state  (state),
      .ctrl   (ctrl)
   );

   // counters and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_ff  <= '0;
         pass_ff  <= '0;
         res_ff   <= '0;
         emit_ff  <= '0;
         count_ff <= '0;
         flags_ff <= '0;
      end else begin
         if (ctrl.clear_run) begin
            proc_ff  <= '0;
            pass_ff  <= '0;
            res_ff   <= '0;
            emit_ff  <= '0;
            count_ff <= '0;
            flags_ff <= '0;
         end
         if (ctrl.res_clear) res_ff <= '0;
         else if (ctrl.res_step) res_ff <= res_ff + RES_W'(1);
         if (ctrl.mark_done) begin
            flags_ff[proc_ff] <= 1'b1;
            count_ff          <= count_ff + PCNT_W'(1);
         end
         if (ctrl.proc_step) begin
            if (status.proc_last) begin
               proc_ff <= '0;
               pass_ff <= pass_ff + PROC_W'(1);
            end else begin
               proc_ff <= proc_ff + PROC_W'(1);
            end
         end
         if (ctrl.emit_beat) emit_ff <= emit_ff + PROC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mark_done) begin
         order_ff[count_ff[PROC_W-1:0]] <= proc_ff;
      end
   end

   // free amounts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            free_ff[r] <= '0;
         end
      end else if (req_fire && (req_bus.cmd == CMD_LOAD_FREE)) begin
         free_ff[req_bus.resource] <= FREE_WIDTH'(req_bus.available);
      end else if (ctrl.free_write) begin
         free_ff[res_ff] <= released;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_beat) begin
         rsp_safe_ff     <= all_done;
         rsp_granted_ff  <= all_done ? order_ff[emit_ff] : '0;
         rsp_position_ff <= all_done ? emit_ff : '0;
         rsp_last_ff     <= status.emit_last;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.safe            = rsp_safe_ff;
   assign rsp_bus.granted_process = rsp_granted_ff;
   assign rsp_bus.position        = rsp_position_ff;
   assign rsp_bus.last            = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state != ST_IDLE) |-> (count_ff <= np_eff))
      else $error("finished count beyond processes in use");

   a_check_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.cmd == CMD_CHECK)) |=> !req_bus.ready)
      else $error("request ready right after a check beat");

   a_unsafe_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.safe) |->
         (rsp_bus.last && (rsp_bus.granted_process == '0) && (rsp_bus.position == '0)))
      else $error("malformed unsafe response");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.safe && rsp_bus.last) |->
         (PCNT_W'(rsp_bus.position) == np_eff - PCNT_W'(1)))
      else $error("last safe beat at wrong position");

endmodule

// ===== hdl/bsc_ram.sv =====
// bsc_ram: generic single-write, single-read memory with registered read data
// no dependencies
module bsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/bsc_alu.sv =====
// bsc_alu: shared adder of free and held units, used for the fit compare
// and for the saturating release; depends on bsc_pkg
module bsc_alu (
   input  logic [bsc_pkg::FREE_WIDTH-1:0] free_units,
   input  logic [bsc_pkg::UNIT_WIDTH-1:0] held_units,
   input  logic [bsc_pkg::UNIT_WIDTH-1:0] claim_units,
   output logic                           fits,
   output logic [bsc_pkg::FREE_WIDTH-1:0] released
);
   import bsc_pkg::*;

   logic [FREE_WIDTH:0] sum;

   assign sum      = {1'b0, free_units} + (FREE_WIDTH + 1)'(held_units);
   assign fits     = (FREE_WIDTH + 1)'(claim_units) <= sum;
   assign released = sum[FREE_WIDTH] ? {FREE_WIDTH{1'b1}} : sum[FREE_WIDTH-1:0];

endmodule

// ===== hdl/bsc_ctrl.sv =====
// bsc_ctrl: sequencer of the safety check, walking passes, processes and resources
// depends on bsc_pkg
module bsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  bsc_pkg::status_type    status,
   output bsc_pkg::state_type     state,
   output bsc_pkg::ctrl_type      ctrl
);
   import bsc_pkg::*;

   state_type state_ff;
   state_type state_in;

   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            state_in = status.skip ? ST_NEXT : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!status.fits) state_in = ST_NEXT;
            else if (status.res_last) state_in = ST_RFETCH;
            else state_in = ST_FETCH;
         end
         ST_RFETCH: begin
            state_in = ST_RADD;
         end
         ST_RADD: begin
            state_in = status.res_last ? ST_NEXT : ST_RFETCH;
         end
         ST_NEXT: begin
            state_in = (status.proc_last && status.pass_last) ? ST_EMIT : ST_SCAN;
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.clear_run = status.start;
         end
         ST_TEST: begin
            ctrl.res_step  = status.fits && !status.res_last;
            ctrl.res_clear = !status.fits || status.res_last;
         end
         ST_RADD: begin
            ctrl.free_write = 1'b1;
            ctrl.res_step   = !status.res_last;
            ctrl.res_clear  = status.res_last;
            ctrl.mark_done  = status.res_last;
         end
         ST_NEXT: begin
            ctrl.proc_step = 1'b1;
         end
         ST_EMIT: begin
            ctrl.emit_beat = status.out_free;
         end
         ST_SCAN, ST_FETCH, ST_RFETCH: begin
            ctrl = '0;
         end
         default: ctrl = '0;
      endcase
   end

endmodule
